[rtl/fsgs_pkg.sv]
// package for the falling sand grid sweep block
// holds grid sizes, material codes, operation codes, state types, the memory request types and the lfsr step
`default_nettype none
package fsgs_pkg;
   localparam int GridWidth  = 64;
   localparam int GridHeight = 64;
   localparam int XW = $clog2(GridWidth);
   localparam int YW = $clog2(GridHeight);
   localparam int AW = XW + YW;
   localparam int CellCount = GridWidth * GridHeight;
   localparam logic [15:0] LfsrMask = 16'hB400;

   typedef enum logic [1:0] {
      MAT_EMPTY = 2'd0, MAT_SAND = 2'd1, MAT_WATER = 2'd2, MAT_SOLID = 2'd3
   } mat_type;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0, OP_READ = 2'd1, OP_SWEEP = 2'd2, OP_NONE = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_INIT, ST_IDLE, ST_READ, ST_CLEAR, ST_VHERE, ST_VMARK, ST_PROBE, ST_PWAIT,
      ST_MOVE, ST_MARK, ST_NEXT, ST_DONE
   } state_type;

   // one cell access toward the grid memory
   typedef struct packed {
      logic          we;
      logic [AW-1:0] addr;
      logic [1:0]    wdata;
   } grid_req_type;

   // one mark access toward the mark memory
   typedef struct packed {
      logic          we;
      logic [AW-1:0] addr;
      logic          wdata;
   } mark_req_type;

   function automatic logic [15:0] lfsr_step(input logic [15:0] v);
      logic [15:0] s;
      s = v >> 1;
      if (v[0]) s = s ^ LfsrMask;
      return s;
   endfunction
endpackage
`default_nettype wire

[rtl/fsgs_ram.sv]
// single port synchronous ram with registered read data
// generic, used for the cell grid and the moved marks
`default_nettype none
module fsgs_ram #(
   parameter int Width = 2,
   parameter int Depth = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wdata,
   output logic      [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

[rtl/fsgs_ctrl.sv]
// sequencer for writes, reads and frame sweeps over the grid memories
// depends on fsgs_pkg; drives the grid and mark ram ports
`default_nettype none
module fsgs_ctrl import fsgs_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  wire logic [1:0]    req_operation,
   input  wire logic [5:0]    req_cell_x,
   input  wire logic [5:0]    req_cell_y,
   input  wire logic [1:0]    req_cell_material,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output logic [1:0]         rsp_read_material,
   output logic               rsp_sweep_done,
   input  wire logic          csr_write,
   input  wire logic [15:0]   csr_data,
   output grid_req_type       grid_req,
   input  wire logic [1:0]    grid_rdata,
   output mark_req_type       mark_req,
   input  wire logic          mark_rdata
);
   state_type st_ff, st_in;
   logic [15:0] lfsr_ff, lfsr_in;
   logic [AW-1:0] ptr_ff, ptr_in;     // clear pointer
   logic [XW-1:0] x_ff, x_in;
   logic [YW-1:0] y_ff, y_in;
   logic [XW-1:0] i_ff, i_in;         // column count within the row
   logic fwd_ff, fwd_in;
   logic sand_ff, sand_in;
   logic [2:0] pr_ff, pr_in;          // probe index 0..5, 6 once all probes are spent
   logic [AW-1:0] dst_ff, dst_in;
   logic [1:0] dmat_ff, dmat_in;
   logic rv_ff, rv_in;
   logic [1:0] rmat_ff, rmat_in;
   logic rdone_ff, rdone_in;
   logic rd_in_ff, rd_in_in;

   wire logic accept = req_valid && !req_stall;
   wire logic in_grid = ({26'd0, req_cell_x} < GridWidth) && ({26'd0, req_cell_y} < GridHeight);
   wire logic [AW-1:0] req_addr = {req_cell_y[YW-1:0], req_cell_x[XW-1:0]};
   wire logic [AW-1:0] here = {y_ff, x_ff};
   wire logic has_left  = x_ff != '0;
   wire logic has_right = x_ff != XW'(GridWidth - 1);
   wire logic has_below = y_ff != YW'(GridHeight - 1);
   wire logic out_free = !rv_ff || !rsp_stall;

   // probe candidate: valid and address
   logic pv;
   logic [AW-1:0] paddr;
   always_comb begin
      pv = 1'b0;
      paddr = here;
      case (pr_ff)
         3'd0: begin pv = has_below; paddr = {y_ff + 1'b1, x_ff}; end
         3'd1: begin pv = has_below && has_left; paddr = {y_ff + 1'b1, x_ff - 1'b1}; end
         3'd2: begin pv = has_below && has_right; paddr = {y_ff + 1'b1, x_ff + 1'b1}; end
         // the bit drawn in this very cycle picks left first
         3'd3: begin pv = !sand_ff && lfsr_ff[0] && has_left; paddr = {y_ff, x_ff - 1'b1}; end
         3'd4: begin pv = !sand_ff && has_right; paddr = {y_ff, x_ff + 1'b1}; end
         3'd5: begin pv = !sand_ff && has_left; paddr = {y_ff, x_ff - 1'b1}; end
         default: begin pv = 1'b0; paddr = here; end
      endcase
   end
   wire logic can_enter = (grid_rdata == MAT_EMPTY) || (sand_ff && grid_rdata == MAT_WATER);

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_INIT:  if (ptr_ff == AW'(CellCount - 1)) st_in = ST_IDLE;
         ST_IDLE: if (accept) begin
            case (op_type'(req_operation))
               OP_READ:  st_in = ST_READ;
               OP_SWEEP: st_in = ST_CLEAR;
               default:  st_in = ST_IDLE;
            endcase
         end
         ST_READ:  st_in = ST_IDLE;
         ST_CLEAR: if (ptr_ff == AW'(CellCount - 1)) st_in = ST_VHERE;
         ST_VHERE: st_in = ST_VMARK;
         ST_VMARK: begin
            if (mark_rdata) st_in = ST_NEXT;
            else if (grid_rdata == MAT_SAND || grid_rdata == MAT_WATER) st_in = ST_PROBE;
            else st_in = ST_MARK;
         end
         ST_PROBE: begin
            if (pr_ff > 3'd5) st_in = ST_MARK;
            else if (pv) st_in = ST_PWAIT;
         end
         ST_PWAIT: st_in = can_enter ? ST_MOVE : ST_PROBE;
         ST_MOVE:  st_in = ST_NEXT;
         ST_MARK:  st_in = ST_NEXT;
         ST_NEXT: begin
            if (i_ff == XW'(GridWidth - 1) && y_ff == '0) st_in = ST_DONE;
            else st_in = ST_VHERE;
         end
         ST_DONE:  if (out_free) st_in = ST_IDLE;
         default:  st_in = ST_IDLE;
      endcase
   end

   // datapath and memory ports
   always_comb begin
      lfsr_in = lfsr_ff; ptr_in = ptr_ff; x_in = x_ff; y_in = y_ff; i_in = i_ff;
      fwd_in = fwd_ff; sand_in = sand_ff; pr_in = pr_ff;
      dst_in = dst_ff; dmat_in = dmat_ff;
      rv_in = rv_ff && rsp_stall; rmat_in = rmat_ff; rdone_in = rdone_ff;
      rd_in_in = rd_in_ff;
      grid_req = '{we: 1'b0, addr: here, wdata: MAT_EMPTY};
      mark_req = '{we: 1'b0, addr: here, wdata: 1'b0};
      req_stall = !(st_ff == ST_IDLE && out_free);
      case (st_ff)
         // empty the grid once after reset
         ST_INIT: begin
            grid_req = '{we: 1'b1, addr: ptr_ff, wdata: MAT_EMPTY};
            ptr_in = ptr_ff + 1'b1;
         end
         ST_IDLE: if (accept) begin
            grid_req.addr = req_addr;
            rd_in_in = in_grid;
            case (op_type'(req_operation))
               OP_WRITE: begin
                  grid_req.we = in_grid;
                  grid_req.wdata = req_cell_material;
                  rv_in = 1'b1; rmat_in = MAT_EMPTY; rdone_in = 1'b0;
               end
               OP_SWEEP: begin
                  ptr_in = '0;
                  fwd_in = lfsr_ff[0];
                  lfsr_in = lfsr_step(lfsr_ff);
                  i_in = '0;
                  y_in = YW'(GridHeight - 1);
                  x_in = lfsr_ff[0] ? '0 : XW'(GridWidth - 1);
               end
               OP_READ: ;
               default: begin rv_in = 1'b1; rmat_in = MAT_EMPTY; rdone_in = 1'b0; end
            endcase
         end
         ST_READ: begin
            rv_in = 1'b1; rdone_in = 1'b0;
            rmat_in = rd_in_ff ? grid_rdata : MAT_EMPTY;
         end
         ST_CLEAR: begin
            mark_req = '{we: 1'b1, addr: ptr_ff, wdata: 1'b0};
            ptr_in = ptr_ff + 1'b1;
         end
         ST_VHERE: begin
            grid_req.addr = here;
            mark_req.addr = here;
         end
         ST_VMARK: begin
            sand_in = grid_rdata == MAT_SAND;
            dmat_in = grid_rdata;
            pr_in = '0;
         end
         ST_PROBE: begin
            // water draws a bit once it has failed all three falls
            if (pr_ff == 3'd3 && !sand_ff) begin
               lfsr_in = lfsr_step(lfsr_ff);
            end
            if (pr_ff == 3'd3 && !sand_ff && !lfsr_ff[0]) begin
               pr_in = 3'd4;
            end else if (pr_ff <= 3'd5 && !pv) begin
               pr_in = pr_ff + 1'b1;
            end else if (pr_ff <= 3'd5) begin
               grid_req.addr = paddr;
               dst_in = paddr;
            end
         end
         ST_PWAIT: begin
            if (can_enter) begin
               // write displaced material back here
               grid_req = '{we: 1'b1, addr: here, wdata: grid_rdata};
            end else begin
               pr_in = pr_ff + 1'b1;
            end
         end
         ST_MOVE: begin
            grid_req = '{we: 1'b1, addr: dst_ff, wdata: dmat_ff};
            mark_req = '{we: 1'b1, addr: dst_ff, wdata: 1'b1};
         end
         ST_MARK: mark_req = '{we: 1'b1, addr: here, wdata: 1'b1};
         ST_NEXT: begin
            if (i_ff == XW'(GridWidth - 1)) begin
               i_in = '0;
               fwd_in = !fwd_ff;
               y_in = y_ff - 1'b1;
               x_in = fwd_ff ? XW'(GridWidth - 1) : '0;
            end else begin
               i_in = i_ff + 1'b1;
               x_in = fwd_ff ? x_ff + 1'b1 : x_ff - 1'b1;
            end
         end
         ST_DONE: if (out_free) begin
            rv_in = 1'b1; rmat_in = MAT_EMPTY; rdone_in = 1'b1;
         end
         default: ;
      endcase
      if (csr_write) lfsr_in = (csr_data == '0) ? 16'd1 : csr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_INIT;
         lfsr_ff <= 16'd1;
         rv_ff <= 1'b0;
         ptr_ff <= '0;
      end else begin
         st_ff <= st_in;
         lfsr_ff <= lfsr_in;
         rv_ff <= rv_in;
         ptr_ff <= ptr_in;
      end
      x_ff <= x_in; y_ff <= y_in; i_ff <= i_in; fwd_ff <= fwd_in;
      sand_ff <= sand_in; pr_ff <= pr_in;
      dst_ff <= dst_in; dmat_ff <= dmat_in; rmat_ff <= rmat_in; rdone_ff <= rdone_in;
      rd_in_ff <= rd_in_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_read_material = rmat_ff;
   assign rsp_sweep_done = rdone_ff;

   a_lfsr_nonzero: assert property (@(posedge clock) disable iff (reset) lfsr_ff != '0)
      else $error("lfsr reached zero");
   a_done_clean: assert property (@(posedge clock) disable iff (reset)
      rv_ff && rdone_ff |-> rmat_ff == MAT_EMPTY) else $error("sweep beat carries material");
   a_idle_only: assert property (@(posedge clock) disable iff (reset)
      accept |-> st_ff == ST_IDLE) else $error("beat taken while busy");
endmodule
`default_nettype wire

[rtl/falling_sand_grid_sweep.sv]
// top level of the falling sand grid sweep block
// depends on fsgs_pkg, fsgs_ram and fsgs_ctrl
`default_nettype none
// After reset the grid is emptied one cell a cycle with req_stall high. A write
// or an unused operation is done straight from idle, a read passes through a read
// state. A sweep first clears the 4096 moved marks, one a cycle, then visits each
// cell in turn through one port of the grid ram and one of the mark ram: a cell
// already marked is skipped, an empty or solid cell is marked, and sand or water
// probes its neighbors in turn until it moves or is marked. The sweep ends with
// the done beat, sent once the response channel is free.
module falling_sand_grid_sweep import fsgs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [5:0]  req_cell_x,
   input  wire logic [5:0]  req_cell_y,
   input  wire logic [1:0]  req_cell_material,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_read_material,
   output logic             rsp_sweep_done,
   input  wire logic        csr_write,
   input  wire logic [15:0] csr_data
);
   grid_req_type grid_req;
   mark_req_type mark_req;
   logic [1:0] grid_rdata;
   logic mark_rdata;

   fsgs_ctrl u_ctrl (.*);

   fsgs_ram #(.Width(2), .Depth(CellCount)) u_grid (
      .clock(clock), .we(grid_req.we), .addr(grid_req.addr),
      .wdata(grid_req.wdata), .rdata(grid_rdata));

   fsgs_ram #(.Width(1), .Depth(CellCount)) u_mark (
      .clock(clock), .we(mark_req.we), .addr(mark_req.addr),
      .wdata(mark_req.wdata), .rdata(mark_rdata));
endmodule
`default_nettype wire

[verif/fsgs_checker.sv]
// checker for the falling sand grid sweep block: watches both channels and the seed port,
// keeps its own grid, marks and lfsr, and compares each result beat
// depends on fsgs_pkg
module fsgs_checker import fsgs_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [5:0]  req_cell_x,
   input  wire logic [5:0]  req_cell_y,
   input  wire logic [1:0]  req_cell_material,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic [1:0]  rsp_read_material,
   input  wire logic        rsp_sweep_done,
   input  wire logic        csr_write,
   input  wire logic [15:0] csr_data,
   output int               fail_count,
   output int               pending_count
);
   typedef struct packed {
      logic [1:0] material;
      logic       done;
   } outcome_type;

   mat_type     grid_model [CellCount];
   logic        moved      [CellCount];
   logic [15:0] lfsr_state;
   outcome_type outcome_queue [$];

   assign pending_count = outcome_queue.size();

   function automatic int cell_index(int x, int y);
      return y * GridWidth + x;
   endfunction

   function automatic logic next_bit();
      logic b;
      b = lfsr_state[0];
      lfsr_state = lfsr_state >> 1;
      if (b) lfsr_state = lfsr_state ^ 16'hB400;
      return b;
   endfunction

   function automatic void relocate(int src, int dst);
      mat_type t;
      t = grid_model[src];
      grid_model[src] = grid_model[dst];
      grid_model[dst] = t;
      moved[dst] = 1'b1;
   endfunction

   function automatic logic enterable(int idx, logic sand);
      return grid_model[idx] == MAT_EMPTY || (sand && grid_model[idx] == MAT_WATER);
   endfunction

   function automatic void settle_cell(int x, int y);
      int here;
      logic sand, has_l, has_r, lf;
      here = cell_index(x, y);
      if (moved[here]) return;
      if (grid_model[here] != MAT_SAND && grid_model[here] != MAT_WATER) begin
         moved[here] = 1'b1;
         return;
      end
      sand = grid_model[here] == MAT_SAND;
      has_l = x > 0;
      has_r = x + 1 < GridWidth;
      if (y + 1 < GridHeight) begin
         if (enterable(cell_index(x, y + 1), sand)) begin
            relocate(here, cell_index(x, y + 1));
            return;
         end
         if (has_l && enterable(cell_index(x - 1, y + 1), sand)) begin
            relocate(here, cell_index(x - 1, y + 1));
            return;
         end
         if (has_r && enterable(cell_index(x + 1, y + 1), sand)) begin
            relocate(here, cell_index(x + 1, y + 1));
            return;
         end
      end
      if (!sand) begin
         lf = next_bit();
         if (lf && has_l && enterable(cell_index(x - 1, y), 1'b0)) begin
            relocate(here, cell_index(x - 1, y));
            return;
         end
         if (has_r && enterable(cell_index(x + 1, y), 1'b0)) begin
            relocate(here, cell_index(x + 1, y));
            return;
         end
         if (has_l && enterable(cell_index(x - 1, y), 1'b0)) begin
            relocate(here, cell_index(x - 1, y));
            return;
         end
      end
      moved[here] = 1'b1;
   endfunction

   function automatic void run_frame();
      logic fwd;
      int y;
      foreach (moved[i]) moved[i] = 1'b0;
      fwd = next_bit();
      for (int r = 0; r < GridHeight; r++) begin
         y = GridHeight - 1 - r;
         for (int i = 0; i < GridWidth; i++)
            settle_cell(fwd ? i : GridWidth - 1 - i, y);
         fwd = !fwd;
      end
   endfunction

   function automatic void report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endfunction

   always @(posedge clock) begin
      outcome_type o, w;
      if (reset) begin
         foreach (grid_model[i]) begin
            grid_model[i] = MAT_EMPTY;
            moved[i] = 1'b0;
         end
         lfsr_state = 16'd1;
         outcome_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_write) lfsr_state = (csr_data != 0) ? csr_data : 16'd1;
         if (rsp_valid && !rsp_stall) begin
            if (outcome_queue.size() == 0) begin
               report_mismatch("unexpected beat", 1, 0);
            end else begin
               w = outcome_queue.pop_front();
               if (rsp_read_material !== w.material)
                  report_mismatch("read_material", rsp_read_material, w.material);
               if (rsp_sweep_done !== w.done)
                  report_mismatch("sweep_done", rsp_sweep_done, w.done);
            end
         end
         if (req_valid && !req_stall) begin
            o = '0;
            case (op_type'(req_operation))
               OP_WRITE: grid_model[cell_index(req_cell_x, req_cell_y)] =
                            mat_type'(req_cell_material);
               OP_READ: o.material = grid_model[cell_index(req_cell_x, req_cell_y)];
               OP_SWEEP: begin
                  run_frame();
                  o.done = 1'b1;
               end
               default: ;
            endcase
            outcome_queue.push_back(o);
         end
      end
   end
endmodule

[verif/testbench.sv]
// testbench top for falling_sand_grid_sweep: clock, reset, stimulus and verdict
// depends on fsgs_pkg, the block and fsgs_checker
module testbench;
   import fsgs_pkg::*;

   localparam int IdleLimit = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_operation = '0;
   logic [5:0]  req_cell_x = '0;
   logic [5:0]  req_cell_y = '0;
   logic [1:0]  req_cell_material = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_read_material;
   logic        rsp_sweep_done;
   logic        csr_write = 1'b0;
   logic [15:0] csr_data = '0;
   int          fail_count;
   int          pending_count;
   int          idle_cycles = 0;
   int          gap_left = 0;

   falling_sand_grid_sweep DUT (.*);
   fsgs_checker checker_inst (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // receiver stall pattern with quiet stretches
   always @(negedge clock) begin
      if ($urandom_range(0, 7) == 0) gap_left <= $urandom_range(0, 40);
      else if (gap_left > 0) gap_left <= gap_left - 1;
      rsp_stall <= (gap_left > 20) ? 1'b0 : ($urandom_range(0, 2) == 0);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IdleLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_beat(op_type op, int x, int y, mat_type m);
      req_valid <= 1'b1;
      req_operation <= op;
      req_cell_x <= 6'(x);
      req_cell_y <= 6'(y);
      req_cell_material <= m;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_seed(logic [15:0] s);
      csr_write <= 1'b1;
      csr_data <= s;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // random beat biased toward a pile near the middle so sweeps have work
   task automatic random_beat();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) send_beat(OP_WRITE, $urandom_range(20, 40), $urandom_range(40, 63),
                            mat_type'($urandom_range(0, 3)));
      else if (r < 65) send_beat(OP_WRITE, $urandom_range(0, 63), $urandom_range(0, 63),
                                 mat_type'($urandom_range(0, 3)));
      else if (r < 85) send_beat(OP_READ, $urandom_range(20, 40), $urandom_range(40, 63),
                                 MAT_EMPTY);
      else if (r < 90) send_beat(OP_READ, $urandom_range(0, 63), $urandom_range(0, 63),
                                 mat_type'($urandom_range(0, 3)));
      else if (r < 97) send_beat(OP_SWEEP, $urandom_range(0, 63), $urandom_range(0, 63),
                                 mat_type'($urandom_range(0, 3)));
      else send_beat(OP_NONE, $urandom_range(0, 63), $urandom_range(0, 63),
                     mat_type'($urandom_range(0, 3)));
      if ($urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   initial begin
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      write_seed(16'hFFFF);
      // corners, every material, edges, sand over water, water spreading sideways
      send_beat(OP_WRITE, 0, 0, MAT_SAND);
      send_beat(OP_WRITE, 63, 0, MAT_WATER);
      send_beat(OP_WRITE, 0, 63, MAT_SOLID);
      send_beat(OP_WRITE, 63, 63, MAT_WATER);
      send_beat(OP_WRITE, 10, 62, MAT_SAND);
      send_beat(OP_WRITE, 10, 63, MAT_WATER);
      send_beat(OP_WRITE, 30, 63, MAT_SOLID);
      send_beat(OP_WRITE, 30, 62, MAT_WATER);
      send_beat(OP_WRITE, 31, 63, MAT_SOLID);
      send_beat(OP_WRITE, 29, 63, MAT_SOLID);
      send_beat(OP_READ, 0, 0, MAT_SOLID);
      send_beat(OP_READ, 63, 0, MAT_EMPTY);
      send_beat(OP_SWEEP, 63, 63, MAT_SOLID);
      send_beat(OP_READ, 0, 1, MAT_EMPTY);
      send_beat(OP_READ, 10, 63, MAT_EMPTY);
      send_beat(OP_READ, 10, 62, MAT_EMPTY);
      send_beat(OP_NONE, 63, 63, MAT_SOLID);
      send_beat(OP_SWEEP, 0, 0, MAT_EMPTY);
      send_beat(OP_READ, 63, 63, MAT_EMPTY);
      send_beat(OP_WRITE, 63, 0, MAT_EMPTY);
      drain();
      write_seed(16'd0);
      send_beat(OP_SWEEP, 0, 0, MAT_EMPTY);
      drain();
      write_seed(16'd1);
      for (int i = 0; i < 50; i++) random_beat();
      drain();
      write_seed(16'(($urandom_range(1, 65535))));
      for (int i = 0; i < 50; i++) random_beat();
      drain();
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule

[falling_sand_grid_sweep.f]
rtl/fsgs_pkg.sv
rtl/fsgs_ram.sv
rtl/fsgs_ctrl.sv
rtl/falling_sand_grid_sweep.sv
verif/fsgs_checker.sv
verif/testbench.sv
